// ----- hdl/imu_attitude_dead_reckoning_3d_defines.svh -----
// Assertion helpers for the dead reckoning block.
`ifndef IMU_ATTITUDE_DEAD_RECKONING_3D_DEFINES_SVH
`define IMU_ATTITUDE_DEAD_RECKONING_3D_DEFINES_SVH

// Same-cycle implication.
`define ADR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ADR_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/imu_adr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package imu_adr_pkg;

    typedef struct packed {
        logic        [1:0]  kind;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [23:0] speed_forward;
        logic signed [23:0] speed_lateral;
        logic signed [23:0] yaw_rate;
    } in_word_t;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [47:0] pos_z;
        logic signed [15:0] att_x;
        logic signed [15:0] att_y;
        logic signed [15:0] att_z;
        logic signed [15:0] att_w;
        logic signed [23:0] out_speed_forward;
        logic signed [23:0] out_yaw_rate;
    } out_word_t;

    localparam logic [1:0] KIND_ATT  = 2'd0;
    localparam logic [1:0] KIND_VEL  = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MATRIX,
        ST_SQRT,
        ST_CINIT,
        ST_CITER,
        ST_AXIS,
        ST_SAT
    } state_t;

    typedef enum logic [4:0] {
        OP_XX, OP_YY, OP_ZZ, OP_WW, OP_XY, OP_WZ, OP_XZ, OP_WY, OP_YZ, OP_WX,
        OP_S21, OP_S22,
        OP_U, OP_V, OP_UCY, OP_VSY, OP_USY, OP_VCY, OP_LSR, OP_FSP,
        OP_DX, OP_DY, OP_DZ
    } op_t;

    // cordic jobs: pitch, roll, yaw vectoring, then their sin/cos
    localparam logic [2:0] JOB_PITCH  = 3'd0;
    localparam logic [2:0] JOB_ROLL   = 3'd1;
    localparam logic [2:0] JOB_YAW    = 3'd2;
    localparam logic [2:0] JOB_SC0    = 3'd3;
    localparam logic [2:0] JOB_YAW_SC = 3'd5;

    localparam int CW = 36;
    localparam int ZW = 34;
    localparam int AW = 33;
    localparam int BW = 34;
    localparam int TW = 28;
    localparam int PW = 48;

    localparam logic signed [ZW-1:0] ANG_PI      = 34'sd1686629713;
    localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd843314857;
    localparam logic signed [CW-1:0] GAIN_Q30    = 36'sd652032874;
    localparam logic signed [PW:0]   POS_MAX     = 49'sd140737488355327;
    localparam logic signed [PW:0]   POS_MIN     = -49'sd140737488355328;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:  r = 34'sd421657428;
            5'd1:  r = 34'sd248918915;
            5'd2:  r = 34'sd131521918;
            5'd3:  r = 34'sd66762579;
            5'd4:  r = 34'sd33510843;
            5'd5:  r = 34'sd16771758;
            5'd6:  r = 34'sd8387925;
            5'd7:  r = 34'sd4194219;
            5'd8:  r = 34'sd2097141;
            5'd9:  r = 34'sd1048575;
            5'd10: r = 34'sd524288;
            5'd11: r = 34'sd262144;
            5'd12: r = 34'sd131072;
            5'd13: r = 34'sd65536;
            5'd14: r = 34'sd32768;
            5'd15: r = 34'sd16384;
            5'd16: r = 34'sd8192;
            5'd17: r = 34'sd4096;
            5'd18: r = 34'sd2048;
            5'd19: r = 34'sd1024;
            5'd20: r = 34'sd512;
            5'd21: r = 34'sd256;
            5'd22: r = 34'sd128;
            5'd23: r = 34'sd64;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/imu_attitude_dead_reckoning_3d.sv -----
// Attitude and velocity words are only stored and give no result.
// A tick with a nonzero attitude runs from accept to result word through
// 23 two-pass products on the shared 33x18 multiplier, 32 square-root steps
// and six CORDIC runs of CORDIC_STEPS iterations on the one shift-add unit.
// s_ready is high only between ticks; one tick in flight at a time.
// Synchronous active-low reset clears attitude, speeds, position; step_time -> 6554.
`timescale 1ns / 1ps
`default_nettype none
module imu_attitude_dead_reckoning_3d #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [15:0]             cfg_wr_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire imu_adr_pkg::in_word_t   s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output imu_adr_pkg::out_word_t       m_data
);
    import imu_adr_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);

    state_t state_reg, state_next;
    op_t    op_reg;
    logic   half_reg;

    logic signed [15:0]   att_reg [4];
    logic signed [23:0]   fwd_reg, lat_reg, rate_reg;
    logic        [15:0]   step_reg;
    logic signed [PW-1:0] pos_reg [3];

    logic signed [50:0]   acc_reg;
    logic signed [31:0]   qp_reg [10];
    logic signed [AW-1:0] s00_reg, s01_reg, s02_reg, s10_reg, s20_reg, s21_reg, s22_reg;
    logic                 gimbal_reg, n20neg_reg;
    logic        [61:0]   sq_reg;
    logic        [62:0]   rad_reg, root_reg;
    logic        [4:0]    k_reg;

    logic signed [CW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic                 zflag_reg, flip_reg;
    logic        [IW-1:0] it_reg;
    logic        [2:0]    job_reg;
    logic signed [ZW-1:0] ang_reg [3];
    logic signed [BW-1:0] cos_reg [3];
    logic signed [BW-1:0] sin_reg [3];
    logic signed [TW-1:0] trm_reg [8];
    logic signed [TW-1:0] axis_reg [3];
    logic signed [TW-1:0] dlt_reg [3];

    logic      m_valid_reg;
    out_word_t m_data_reg;

    logic accept, att_live, can_write;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign att_live  = (att_reg[0] != '0) || (att_reg[1] != '0) ||
                       (att_reg[2] != '0) || (att_reg[3] != '0);
    assign can_write = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // shared multiplier, two passes per product (low half then high half of b)
    logic signed [AW-1:0] op_a;
    logic signed [BW-1:0] op_b;
    logic signed [17:0]   mul_b;
    logic signed [50:0]   prod;
    logic signed [66:0]   full, rnd30, rnd16;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (op_reg)
            OP_XX:  begin op_a = AW'(att_reg[0]); op_b = BW'(att_reg[0]); end
            OP_YY:  begin op_a = AW'(att_reg[1]); op_b = BW'(att_reg[1]); end
            OP_ZZ:  begin op_a = AW'(att_reg[2]); op_b = BW'(att_reg[2]); end
            OP_WW:  begin op_a = AW'(att_reg[3]); op_b = BW'(att_reg[3]); end
            OP_XY:  begin op_a = AW'(att_reg[0]); op_b = BW'(att_reg[1]); end
            OP_WZ:  begin op_a = AW'(att_reg[3]); op_b = BW'(att_reg[2]); end
            OP_XZ:  begin op_a = AW'(att_reg[0]); op_b = BW'(att_reg[2]); end
            OP_WY:  begin op_a = AW'(att_reg[3]); op_b = BW'(att_reg[1]); end
            OP_YZ:  begin op_a = AW'(att_reg[1]); op_b = BW'(att_reg[2]); end
            OP_WX:  begin op_a = AW'(att_reg[3]); op_b = BW'(att_reg[0]); end
            OP_S21: begin op_a = s21_reg;         op_b = BW'(s21_reg); end
            OP_S22: begin op_a = s22_reg;         op_b = BW'(s22_reg); end
            OP_U:   begin op_a = AW'(fwd_reg);    op_b = cos_reg[0]; end
            OP_V:   begin op_a = AW'(lat_reg);    op_b = cos_reg[1]; end
            OP_UCY: begin op_a = AW'(trm_reg[0]); op_b = cos_reg[2]; end
            OP_VSY: begin op_a = AW'(trm_reg[1]); op_b = sin_reg[2]; end
            OP_USY: begin op_a = AW'(trm_reg[0]); op_b = sin_reg[2]; end
            OP_VCY: begin op_a = AW'(trm_reg[1]); op_b = cos_reg[2]; end
            OP_LSR: begin op_a = AW'(lat_reg);    op_b = sin_reg[1]; end
            OP_FSP: begin op_a = AW'(fwd_reg);    op_b = sin_reg[0]; end
            OP_DX:  begin op_a = AW'(axis_reg[0]); op_b = BW'(step_reg); end
            OP_DY:  begin op_a = AW'(axis_reg[1]); op_b = BW'(step_reg); end
            OP_DZ:  begin op_a = AW'(axis_reg[2]); op_b = BW'(step_reg); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    assign mul_b = half_reg ? op_b[BW-1:16] : {2'b00, op_b[15:0]};
    assign prod  = op_a * mul_b;
    assign full  = 67'(acc_reg) + (67'(prod) <<< 16);
    assign rnd30 = full + (67'sd1 <<< 29);
    assign rnd16 = full + (67'sd1 <<< 15);

    // rotation matrix, scaled by |q|^2
    logic signed [34:0] n00, n01, n02, n10, n20, n21, n22;
    always_comb begin
        n00 = 35'(qp_reg[3]) + 35'(qp_reg[0]) - 35'(qp_reg[1]) - 35'(qp_reg[2]);
        n01 = (35'(qp_reg[4]) - 35'(qp_reg[5])) <<< 1;
        n02 = (35'(qp_reg[6]) + 35'(qp_reg[7])) <<< 1;
        n10 = (35'(qp_reg[4]) + 35'(qp_reg[5])) <<< 1;
        n20 = (35'(qp_reg[6]) - 35'(qp_reg[7])) <<< 1;
        n21 = (35'(qp_reg[8]) + 35'(qp_reg[9])) <<< 1;
        n22 = 35'(qp_reg[3]) - 35'(qp_reg[0]) - 35'(qp_reg[1]) + 35'(qp_reg[2]);
    end

    // square root step
    logic [62:0] sq_bit;
    logic [63:0] sq_trial;
    assign sq_bit   = 63'(1) << {k_reg, 1'b0};
    assign sq_trial = 64'(root_reg) + 64'(sq_bit);

    // cordic operand selection
    logic signed [CW-1:0] vx_in, vy_in;
    logic signed [ZW-1:0] ang_in;
    logic                 vect;
    always_comb begin
        vx_in = '0;
        vy_in = '0;
        case (job_reg)
            JOB_PITCH: begin
                vy_in = -(CW'(s20_reg));
                vx_in = CW'({1'b0, root_reg[31:0]});
            end
            JOB_ROLL: begin
                if (!gimbal_reg) begin
                    vy_in = CW'(s21_reg);
                    vx_in = CW'(s22_reg);
                end else if (n20neg_reg) begin
                    vy_in = CW'(s01_reg);
                    vx_in = CW'(s02_reg);
                end else begin
                    vy_in = -(CW'(s01_reg));
                    vx_in = -(CW'(s02_reg));
                end
            end
            JOB_YAW: begin
                if (!gimbal_reg) begin
                    vy_in = CW'(s10_reg);
                    vx_in = CW'(s00_reg);
                end
            end
            default: begin
                vx_in = '0;
                vy_in = '0;
            end
        endcase
    end
    assign vect   = (job_reg <= JOB_YAW);
    assign ang_in = ang_reg[2'(job_reg - JOB_SC0)];

    logic signed [CW-1:0] dx, dy, cx_n, cy_n;
    logic signed [ZW-1:0] tab, cz_n;
    logic                 rot_sub, it_last;
    assign dx      = cx_reg >>> it_reg;
    assign dy      = cy_reg >>> it_reg;
    assign tab     = atan_entry(5'(it_reg));
    assign rot_sub = vect ? cy_reg[CW-1] : !cz_reg[ZW-1];
    assign cx_n    = rot_sub ? cx_reg - dy : cx_reg + dy;
    assign cy_n    = rot_sub ? cy_reg + dx : cy_reg - dx;
    assign cz_n    = rot_sub ? cz_reg - tab : cz_reg + tab;
    assign it_last = (it_reg == IW'(CORDIC_STEPS - 1));

    // saturating accumulate
    logic signed [PW:0]   pos_sum [3];
    logic signed [PW-1:0] pos_new [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            pos_sum[a] = (PW+1)'(pos_reg[a]) + (PW+1)'(dlt_reg[a]);
            if (pos_sum[a] > POS_MAX) begin
                pos_new[a] = PW'(POS_MAX);
            end else if (pos_sum[a] < POS_MIN) begin
                pos_new[a] = PW'(POS_MIN);
            end else begin
                pos_new[a] = pos_sum[a][PW-1:0];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.kind == KIND_TICK && att_live) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (half_reg) begin
                    case (op_reg)
                        OP_WX:   state_next = ST_MATRIX;
                        OP_S22:  state_next = ST_SQRT;
                        OP_FSP:  state_next = ST_AXIS;
                        OP_DZ:   state_next = ST_SAT;
                        default: state_next = ST_MUL;
                    endcase
                end
            end
            ST_MATRIX: state_next = ST_MUL;
            ST_SQRT: begin
                if (k_reg == 5'd0) begin
                    state_next = ST_CINIT;
                end
            end
            ST_CINIT: state_next = ST_CITER;
            ST_CITER: begin
                if (it_last) begin
                    state_next = (job_reg == JOB_YAW_SC) ? ST_MUL : ST_CINIT;
                end
            end
            ST_AXIS: state_next = ST_MUL;
            ST_SAT: begin
                if (can_write) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            step_reg    <= 16'd6554;
            fwd_reg     <= '0;
            lat_reg     <= '0;
            rate_reg    <= '0;
            for (int a = 0; a < 4; a++) att_reg[a] <= '0;
            for (int a = 0; a < 3; a++) pos_reg[a] <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data;
            end
            if (accept && s_data.kind == KIND_ATT) begin
                att_reg[0] <= s_data.quat_x;
                att_reg[1] <= s_data.quat_y;
                att_reg[2] <= s_data.quat_z;
                att_reg[3] <= s_data.quat_w;
            end
            if (accept && s_data.kind == KIND_VEL) begin
                fwd_reg  <= s_data.speed_forward;
                lat_reg  <= s_data.speed_lateral;
                rate_reg <= s_data.yaw_rate;
            end
            if (state_reg == ST_SAT && can_write) begin
                m_valid_reg <= 1'b1;
                for (int a = 0; a < 3; a++) pos_reg[a] <= pos_new[a];
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                op_reg   <= OP_XX;
                half_reg <= 1'b0;
                job_reg  <= JOB_PITCH;
            end
            ST_MUL: begin
                half_reg <= !half_reg;
                if (!half_reg) begin
                    acc_reg <= prod;
                end else begin
                    if (op_reg <= OP_WX) begin
                        qp_reg[4'(op_reg)] <= full[31:0];
                    end else if (op_reg == OP_S21) begin
                        sq_reg <= full[61:0];
                    end else if (op_reg == OP_S22) begin
                        rad_reg  <= 63'(sq_reg) + 63'(full[61:0]);
                        root_reg <= '0;
                        k_reg    <= 5'd31;
                    end else if (op_reg <= OP_FSP) begin
                        trm_reg[3'(op_reg - OP_U)] <= rnd30[30+TW-1:30];
                    end else begin
                        dlt_reg[2'(op_reg - OP_DX)] <= rnd16[16+TW-1:16];
                    end
                    op_reg <= op_t'(5'(op_reg) + 5'd1);
                end
            end
            ST_MATRIX: begin
                s00_reg    <= n00[34:2];
                s01_reg    <= n01[34:2];
                s02_reg    <= n02[34:2];
                s10_reg    <= n10[34:2];
                s20_reg    <= n20[34:2];
                s21_reg    <= n21[34:2];
                s22_reg    <= n22[34:2];
                gimbal_reg <= (n21 == '0) && (n22 == '0);
                n20neg_reg <= n20[34];
            end
            ST_SQRT: begin
                if ({1'b0, rad_reg} >= sq_trial) begin
                    rad_reg  <= rad_reg - sq_trial[62:0];
                    root_reg <= (root_reg >> 1) + sq_bit;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                k_reg <= k_reg - 5'd1;
            end
            ST_CINIT: begin
                it_reg <= '0;
                if (vect) begin
                    zflag_reg <= (vx_in == '0) && (vy_in == '0);
                    flip_reg  <= 1'b0;
                    if (vx_in < 0) begin
                        cz_reg <= (vy_in >= 0) ? ANG_PI : -ANG_PI;
                        cx_reg <= -vx_in;
                        cy_reg <= -vy_in;
                    end else begin
                        cz_reg <= '0;
                        cx_reg <= vx_in;
                        cy_reg <= vy_in;
                    end
                end else begin
                    zflag_reg <= 1'b0;
                    cx_reg    <= GAIN_Q30;
                    cy_reg    <= '0;
                    if (ang_in > ANG_HALF_PI) begin
                        cz_reg   <= ang_in - ANG_PI;
                        flip_reg <= 1'b1;
                    end else if (ang_in < -ANG_HALF_PI) begin
                        cz_reg   <= ang_in + ANG_PI;
                        flip_reg <= 1'b1;
                    end else begin
                        cz_reg   <= ang_in;
                        flip_reg <= 1'b0;
                    end
                end
            end
            ST_CITER: begin
                cx_reg <= cx_n;
                cy_reg <= cy_n;
                cz_reg <= cz_n;
                it_reg <= it_reg + IW'(1);
                if (it_last) begin
                    job_reg <= job_reg + 3'd1;
                    if (vect) begin
                        ang_reg[job_reg[1:0]] <= zflag_reg ? '0 : cz_n;
                    end else begin
                        cos_reg[2'(job_reg - JOB_SC0)] <= flip_reg ? BW'(-cx_n) : BW'(cx_n);
                        sin_reg[2'(job_reg - JOB_SC0)] <= flip_reg ? BW'(-cy_n) : BW'(cy_n);
                    end
                end
            end
            ST_AXIS: begin
                axis_reg[0] <= trm_reg[2] - trm_reg[3];
                axis_reg[1] <= trm_reg[4] + trm_reg[5];
                axis_reg[2] <= trm_reg[6] - trm_reg[7];
            end
            ST_SAT: begin
                if (can_write) begin
                    m_data_reg.pos_x             <= pos_new[0];
                    m_data_reg.pos_y             <= pos_new[1];
                    m_data_reg.pos_z             <= pos_new[2];
                    m_data_reg.att_x             <= att_reg[0];
                    m_data_reg.att_y             <= att_reg[1];
                    m_data_reg.att_z             <= att_reg[2];
                    m_data_reg.att_w             <= att_reg[3];
                    m_data_reg.out_speed_forward <= fwd_reg;
                    m_data_reg.out_yaw_rate      <= rate_reg;
                end
            end
            default: begin
                half_reg <= 1'b0;
            end
        endcase
    end

`include "imu_attitude_dead_reckoning_3d_defines.svh"

    `ADR_ASSERT_NXT(a_no_att_tick, accept && s_data.kind == KIND_TICK && !att_live, state_reg == ST_IDLE, "tick without attitude started work")
    `ADR_ASSERT_NXT(a_tick_start, accept && s_data.kind == KIND_TICK && att_live, state_reg == ST_MUL && op_reg == OP_XX && !half_reg, "tick did not start at first product")
    `ADR_ASSERT_IMP(a_job_range, state_reg == ST_CITER || state_reg == ST_CINIT, job_reg <= JOB_YAW_SC, "cordic job out of range")
    `ADR_ASSERT_NXT(a_result_word, state_reg == ST_SAT && can_write, m_valid_reg && state_reg == ST_IDLE, "result word not posted")

endmodule
`default_nettype wire

// ----- test/imu_attitude_dead_reckoning_3d_tb.sv -----
`timescale 1ns / 1ps
module imu_attitude_dead_reckoning_3d_tb;
    import imu_adr_pkg::*;

    localparam int  STEPS = 16;
    localparam int  IN_BITS = $bits(in_word_t);
    localparam longint RUN_LIMIT = 2000000;
    localparam int  SETTLE = 250;
    localparam longint P_MAX = 64'sd140737488355327;
    localparam longint P_MIN = -64'sd140737488355328;

    class odom_scoreboard;
        out_word_t odom_q[$];
        longint quat[4];
        longint fwd, lat, turn;
        longint pos[3];
        longint dt;
        int errors;
        int results_seen;
        int ticks_dropped;

        function new();
            foreach (quat[i]) quat[i] = 0;
            foreach (pos[i]) pos[i] = 0;
            fwd = 0; lat = 0; turn = 0; dt = 6554;
            errors = 0; results_seen = 0; ticks_dropped = 0;
        endfunction

        function longint mul_q30(longint a, longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned res, bits;
            res = 0;
            bits = 64'd1 << 62;
            while (bits > v) bits = bits >> 2;
            while (bits != 0) begin
                if (v >= res + bits) begin
                    v = v - (res + bits);
                    res = (res >> 1) + bits;
                end else begin
                    res = res >> 1;
                end
                bits = bits >> 2;
            end
            return res;
        endfunction

        function longint angle_of(longint yv, longint xv);
            longint base, z, dx, dy;
            base = 0; z = 0;
            if (xv == 0 && yv == 0) return 0;
            if (xv < 0) begin
                base = (yv >= 0) ? longint'(ANG_PI) : -longint'(ANG_PI);
                xv = -xv;
                yv = -yv;
            end
            for (int i = 0; i < STEPS; i++) begin
                dx = xv >>> i;
                dy = yv >>> i;
                if (yv < 0) begin
                    xv = xv - dy; yv = yv + dx; z = z - longint'(atan_entry(5'(i)));
                end else begin
                    xv = xv + dy; yv = yv - dx; z = z + longint'(atan_entry(5'(i)));
                end
            end
            return base + z;
        endfunction

        function void sin_cos(longint z, output longint c, output longint s);
            longint xv, yv, dx, dy;
            bit flip;
            xv = longint'(GAIN_Q30); yv = 0; flip = 0;
            if (z > longint'(ANG_HALF_PI)) begin
                z = z - longint'(ANG_PI); flip = 1;
            end else if (z < -longint'(ANG_HALF_PI)) begin
                z = z + longint'(ANG_PI); flip = 1;
            end
            for (int i = 0; i < STEPS; i++) begin
                dx = xv >>> i;
                dy = yv >>> i;
                if (z >= 0) begin
                    xv = xv - dy; yv = yv + dx; z = z - longint'(atan_entry(5'(i)));
                end else begin
                    xv = xv + dy; yv = yv - dx; z = z + longint'(atan_entry(5'(i)));
                end
            end
            c = flip ? -xv : xv;
            s = flip ? -yv : yv;
        endfunction

        function longint clamp_add(longint p, longint d);
            longint r;
            r = p + d;
            if (r > P_MAX) return P_MAX;
            if (r < P_MIN) return P_MIN;
            return r;
        endfunction

        function void set_step(longint v);
            dt = v;
        endfunction

        function int pending();
            return odom_q.size();
        endfunction

        function void note_input(in_word_t w);
            longint x, y, z, q, n00, n01, n02, n10, n20, n21, n22, s21, s22;
            longint pitch, roll, yaw, cp, sp, cr, sr, cy, sy, u, v, ax, ay, az;
            longint unsigned h;
            out_word_t o;
            if (w.kind == KIND_ATT) begin
                quat[0] = longint'(w.quat_x); quat[1] = longint'(w.quat_y);
                quat[2] = longint'(w.quat_z); quat[3] = longint'(w.quat_w);
                return;
            end
            if (w.kind == KIND_VEL) begin
                fwd = longint'(w.speed_forward);
                lat = longint'(w.speed_lateral);
                turn = longint'(w.yaw_rate);
                return;
            end
            if (w.kind != KIND_TICK) return;
            x = quat[0]; y = quat[1]; z = quat[2]; q = quat[3];
            if (x == 0 && y == 0 && z == 0 && q == 0) begin
                ticks_dropped++;
                return;
            end
            n00 = q * q + x * x - y * y - z * z;
            n01 = 2 * (x * y - q * z);
            n02 = 2 * (x * z + q * y);
            n10 = 2 * (x * y + q * z);
            n20 = 2 * (x * z - q * y);
            n21 = 2 * (y * z + q * x);
            n22 = q * q - x * x - y * y + z * z;
            s21 = n21 >>> 2;
            s22 = n22 >>> 2;
            h = int_sqrt(longint'(s21 * s21) + longint'(s22 * s22));
            pitch = angle_of(-(n20 >>> 2), longint'(h));
            if (n21 == 0 && n22 == 0) begin
                yaw = 0;
                if (n20 < 0) roll = angle_of(n01 >>> 2, n02 >>> 2);
                else roll = angle_of(-(n01 >>> 2), -(n02 >>> 2));
            end else begin
                roll = angle_of(s21, s22);
                yaw = angle_of(n10 >>> 2, n00 >>> 2);
            end
            sin_cos(pitch, cp, sp);
            sin_cos(roll, cr, sr);
            sin_cos(yaw, cy, sy);
            u = mul_q30(fwd, cp);
            v = mul_q30(lat, cr);
            ax = mul_q30(u, cy) - mul_q30(v, sy);
            ay = mul_q30(u, sy) + mul_q30(v, cy);
            az = mul_q30(lat, sr) - mul_q30(fwd, sp);
            pos[0] = clamp_add(pos[0], (ax * dt + 32768) >>> 16);
            pos[1] = clamp_add(pos[1], (ay * dt + 32768) >>> 16);
            pos[2] = clamp_add(pos[2], (az * dt + 32768) >>> 16);
            o.pos_x = 48'(pos[0]); o.pos_y = 48'(pos[1]); o.pos_z = 48'(pos[2]);
            o.att_x = 16'(x); o.att_y = 16'(y); o.att_z = 16'(z); o.att_w = 16'(q);
            o.out_speed_forward = 24'(fwd);
            o.out_yaw_rate = 24'(turn);
            odom_q.push_back(o);
        endfunction

        function void check_result(out_word_t a);
            out_word_t e;
            results_seen++;
            if (odom_q.size() == 0) begin
                $error("unexpected result word");
                errors++;
                return;
            end
            e = odom_q.pop_front();
            if (a.pos_x !== e.pos_x) begin
                $error("pos_x exp %0d got %0d", e.pos_x, a.pos_x); errors++;
            end
            if (a.pos_y !== e.pos_y) begin
                $error("pos_y exp %0d got %0d", e.pos_y, a.pos_y); errors++;
            end
            if (a.pos_z !== e.pos_z) begin
                $error("pos_z exp %0d got %0d", e.pos_z, a.pos_z); errors++;
            end
            if (a.att_x !== e.att_x) begin
                $error("att_x exp %0d got %0d", e.att_x, a.att_x); errors++;
            end
            if (a.att_y !== e.att_y) begin
                $error("att_y exp %0d got %0d", e.att_y, a.att_y); errors++;
            end
            if (a.att_z !== e.att_z) begin
                $error("att_z exp %0d got %0d", e.att_z, a.att_z); errors++;
            end
            if (a.att_w !== e.att_w) begin
                $error("att_w exp %0d got %0d", e.att_w, a.att_w); errors++;
            end
            if (a.out_speed_forward !== e.out_speed_forward) begin
                $error("out_speed_forward exp %0d got %0d",
                       e.out_speed_forward, a.out_speed_forward);
                errors++;
            end
            if (a.out_yaw_rate !== e.out_yaw_rate) begin
                $error("out_yaw_rate exp %0d got %0d", e.out_yaw_rate, a.out_yaw_rate);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [15:0] cfg_wr_data = '0;
    logic s_valid = 0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    out_word_t m_data;

    bit calm = 0;
    bit hold_req = 0;
    longint cycles = 0;
    int words_in = 0;
    odom_scoreboard sb = new();

    always #5 aclk = ~aclk;

    imu_attitude_dead_reckoning_3d uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_input(s_data);
                words_in++;
            end
            if (m_valid && m_ready) sb.check_result(m_data);
        end
    end

    // result side backpressure
    initial begin
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 0;
                repeat (1500) @(posedge aclk);
                hold_req = 0;
            end else if (calm || $urandom_range(0, 3) != 0) begin
                m_ready <= 1;
            end else begin
                m_ready <= 0;
                repeat ($urandom_range(0, 17)) @(posedge aclk);
            end
        end
    end

    task automatic send_word(in_word_t w);
        int gap;
        gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        if (gap != 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_step(logic [15:0] v);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.set_step(v);
    endtask

    function automatic in_word_t mk_att(int x, int y, int z, int w);
        in_word_t r;
        r = '0;
        r.kind = KIND_ATT;
        r.quat_x = 16'(x); r.quat_y = 16'(y); r.quat_z = 16'(z); r.quat_w = 16'(w);
        return r;
    endfunction

    function automatic in_word_t mk_vel(int f, int l, int t);
        in_word_t r;
        r = '0;
        r.kind = KIND_VEL;
        r.speed_forward = 24'(f); r.speed_lateral = 24'(l); r.yaw_rate = 24'(t);
        return r;
    endfunction

    function automatic in_word_t mk_tick();
        in_word_t r;
        r = in_word_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        r.kind = KIND_TICK;
        return r;
    endfunction

    function automatic logic [23:0] rand_speed();
        case ($urandom_range(0, 5))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 131072)) - 65536);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic in_word_t rand_att();
        int a;
        a = $urandom_range(0, 32767);
        case ($urandom_range(0, 9))
            0: return mk_att(0, 0, 0, 0);
            1: return mk_att(0, a, 0, a);
            2: return mk_att(0, -a, 0, a);
            3: return mk_att(a, a, -a, a);
            4: return mk_att(16'h8000, 16'h8000, 16'h8000, 16'h8000);
            default: return mk_att($urandom, $urandom, $urandom, $urandom);
        endcase
    endfunction

    function automatic in_word_t rand_word();
        in_word_t r;
        r = in_word_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        case ($urandom_range(0, 19))
            0: r.kind = 2'd3;
            1, 2, 3, 4: r = rand_att();
            5, 6, 7, 8, 9: r = mk_vel(rand_speed(), rand_speed(), $urandom);
            default: r.kind = KIND_TICK;
        endcase
        if ($urandom_range(0, 7) == 0) begin
            r = in_word_t'(IN_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        end
        return r;
    endfunction

    task automatic run_random(int count, bit with_hold);
        for (int i = 0; i < count; i++) begin
            if (with_hold && i == count / 2) hold_req = 1;
            send_word(rand_word());
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: no attitude, unused kind, extremes, gimbal lock both ways
        send_word(mk_tick());
        send_word(mk_vel(24'h7fffff, 24'h800000, 24'h7fffff));
        send_word(mk_tick());
        begin
            in_word_t u;
            u = mk_att(100, 200, 300, 400);
            u.kind = 2'd3;
            send_word(u);
        end
        send_word(mk_tick());
        send_word(mk_att(0, 0, 0, 32767));
        send_word(mk_tick());
        send_word(mk_att(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_word(mk_tick());
        send_word(mk_att(32767, 32767, 32767, 32767));
        send_word(mk_vel(24'h800000, 24'h7fffff, 24'h800000));
        send_word(mk_tick());
        send_word(mk_att(0, 23170, 0, 23170));
        send_word(mk_tick());
        send_word(mk_att(0, -23170, 0, 23170));
        send_word(mk_tick());
        send_word(mk_att(16384, 16384, -16384, 16384));
        send_word(mk_tick());
        send_word(mk_att(3, 0, 0, 1));
        send_word(mk_tick());
        send_word(mk_att(0, 0, 0, 0));
        send_word(mk_tick());
        drain();

        write_step(16'hffff);
        send_word(mk_att(1000, -2000, 3000, 30000));
        send_word(mk_vel(24'h7fffff, 24'h7fffff, 24'h000100));
        send_word(mk_tick());
        drain();

        write_step(16'd0);
        run_random(300, 0);
        drain();
        write_step(16'd1);
        run_random(400, 1);
        drain();
        write_step(16'($urandom_range(1, 65535)));
        run_random(400, 0);
        drain();
        write_step(16'hffff);
        run_random(350, 0);
        calm = 1;
        run_random(150, 0);
        drain();

        $display("Run took %0d input words; %0d position results checked, %0d ticks without attitude.",
                 words_in, sb.results_seen, sb.ticks_dropped);
        $display("Step times covered zero, one, full scale, a random value and the reset value.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/imu_adr_pkg.sv
hdl/imu_attitude_dead_reckoning_3d.sv
test/imu_attitude_dead_reckoning_3d_tb.sv
